// ===== rtl/sbr_pkg.sv =====
// Shared types, constants and the response byte table for the STUN binding responder.
// No dependencies; the RTL modules and the testbench import this package.
package sbr_pkg;

    // Default sizes, handed to the top level parameters
    localparam int SBR_TABLE_DEPTH  = 4096;
    localparam int SBR_MAX_DATAGRAM = 512;

    // Protocol constants
    localparam int          HDR_LEN   = 20;
    localparam int          TXID_BASE = 8;
    localparam logic [31:0] COOKIE    = 32'h2112_A442;
    localparam logic [31:0] HASH_MUL  = 32'd2654435761;
    localparam logic [15:0] PLIM_DFLT = 16'd10;
    localparam logic [15:0] GLIM_DFLT = 16'd500;

    // Input opcodes
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // Verdict codes
    localparam logic [1:0] VERDICT_PASS = 2'd0;
    localparam logic [1:0] VERDICT_DROP = 2'd1;
    localparam logic [1:0] VERDICT_RESP = 2'd2;

    // Configuration register indexes
    localparam int         CFG_IDX_W       = 4;
    localparam int         CFG_DATA_W      = 32;
    localparam logic [3:0] CFG_ENABLE      = 4'd0;
    localparam logic [3:0] CFG_PER_SOURCE  = 4'd1;
    localparam logic [3:0] CFG_GLOBAL      = 4'd2;
    localparam logic [3:0] CFG_WINDOW      = 4'd3;

    // Reset values of the registers
    localparam logic [15:0] PLIM_RST   = 16'd10;
    localparam logic [15:0] GLIM_RST   = 16'd500;
    localparam logic [19:0] WINDOW_RST = 20'd1000;

    // Response length
    localparam logic [4:0] RESP_LAST = 5'd31;

    // Transaction ID, element 0 is wire byte 8
    typedef logic [11:0][7:0] txid_t;

    // Finished datagram, handed from the parser to the rate stage
    typedef struct packed {
        logic        valid;
        logic        well_formed;
        logic [31:0] addr;
        logic [15:0] port;
        txid_t       txid;
    } sbr_done_t;

    // Outcome of one datagram, handed from the rate stage to the response stage
    typedef struct packed {
        logic [1:0]  verdict;
        logic [31:0] addr;
        logic [15:0] port;
        txid_t       txid;
    } sbr_result_t;

    // One bucket of the per-source table
    typedef struct packed {
        logic [31:0] addr;
        logic [31:0] win_start;
        logic [15:0] count;
    } sbr_bucket_t;

    // Magic cookie byte, index 0 is the first wire byte
    function automatic logic [7:0] cookie_byte(input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0:    b = COOKIE[31:24];
            2'd1:    b = COOKIE[23:16];
            2'd2:    b = COOKIE[15:8];
            default: b = COOKIE[7:0];
        endcase
        return b;
    endfunction

    // Byte idx of the 32-byte Binding Success Response
    function automatic logic [7:0] resp_byte(input logic [4:0] idx, input txid_t txid,
                                             input logic [31:0] addr, input logic [15:0] port);
        logic [7:0] b;
        b = 8'h00;
        case (idx)
            5'd0:    b = 8'h01;
            5'd1:    b = 8'h01;
            5'd2:    b = 8'h00;
            5'd3:    b = 8'h0C;
            5'd4:    b = COOKIE[31:24];
            5'd5:    b = COOKIE[23:16];
            5'd6:    b = COOKIE[15:8];
            5'd7:    b = COOKIE[7:0];
            5'd8, 5'd9, 5'd10, 5'd11, 5'd12, 5'd13,
            5'd14, 5'd15, 5'd16, 5'd17, 5'd18, 5'd19:
                     b = txid[4'(idx - 5'(TXID_BASE))];
            5'd20:   b = 8'h00;
            5'd21:   b = 8'h20;
            5'd22:   b = 8'h00;
            5'd23:   b = 8'h08;
            5'd24:   b = 8'h00;
            5'd25:   b = 8'h01;
            5'd26:   b = port[15:8] ^ COOKIE[31:24];
            5'd27:   b = port[7:0]  ^ COOKIE[23:16];
            5'd28:   b = addr[31:24] ^ COOKIE[31:24];
            5'd29:   b = addr[23:16] ^ COOKIE[23:16];
            5'd30:   b = addr[15:8]  ^ COOKIE[15:8];
            default: b = addr[7:0]   ^ COOKIE[7:0];
        endcase
        return b;
    endfunction

endpackage

// ===== rtl/sbr_ifs.sv =====
// Channel interfaces of the STUN binding responder: input items, results, config writes.
// No dependencies.

// Input items: datagram bytes and time ticks
interface sbr_rx_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic [7:0]  data_byte;
    logic        last;
    logic [31:0] source_address;
    logic [15:0] source_port;

    modport source (output valid, opcode, data_byte, last, source_address, source_port,
                    input ready);
    modport sink   (input valid, opcode, data_byte, last, source_address, source_port,
                    output ready);
endinterface

// Result items
interface sbr_tx_if;
    logic       valid;
    logic       ready;
    logic [1:0] verdict;
    logic [7:0] out_byte;
    logic       out_last;

    modport source (output valid, verdict, out_byte, out_last, input ready);
    modport sink   (input valid, verdict, out_byte, out_last, output ready);
endinterface

// Configuration register writes
interface sbr_cfg_if;
    logic        valid;
    logic        ready;
    logic [3:0]  index;
    logic [31:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/stun_binding_responder_core.sv =====
// Top level of the STUN binding responder: config registers and handshake glue.
// Depends on sbr_pkg, sbr_ifs, sbr_parse, sbr_rate and sbr_resp.
//
//  channel  dir  beat contents
//  -------  ---  ------------------------------------------------------------
//  rx       in   opcode, data_byte, last, source_address, source_port
//  tx       out  verdict, out_byte, out_last
//  cfg      in   index (register number), data (written value)
//
//  A byte or tick is taken each cycle that rx is ready. The last byte of a
//  datagram moves to a lookup stage that reads the bucket memory and decides
//  in the next cycle. A verdict takes one tx beat; an answered request takes
//  32 tx beats, so the response sequencer sets the sustained rate.
//  Clearing aside, rx stalls only while a decided datagram waits for the sequencer.
//  After reset the bucket memory is cleared, one entry a cycle, all TABLE_DEPTH
//  entries (4096 by default); rx is not ready during that pass, cfg always is.
module stun_binding_responder_core
    import sbr_pkg::*;
#(
    parameter int TABLE_DEPTH  = SBR_TABLE_DEPTH,
    parameter int MAX_DATAGRAM = SBR_MAX_DATAGRAM
)
(
    input  logic      clk,
    input  logic      rst_n,
    sbr_rx_if.sink    rx,
    sbr_tx_if.source  tx,
    sbr_cfg_if.sink   cfg
);

    logic        enable_reg;
    logic [15:0] plim_reg;
    logic [15:0] glim_reg;
    logic [19:0] window_reg;

    logic        rx_fire, byte_fire, tick;
    logic        clearing, s1_busy, go, gen_free;
    sbr_done_t   done;
    sbr_result_t result;

    // Input handshake
    assign rx.ready  = ~clearing & (~s1_busy | go);
    assign rx_fire   = rx.valid & rx.ready;
    assign byte_fire = rx_fire & (rx.opcode == OP_BYTE);
    assign tick      = rx_fire & (rx.opcode == OP_TICK);

    // Configuration registers
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b0;
            plim_reg   <= PLIM_RST;
            glim_reg   <= GLIM_RST;
            window_reg <= WINDOW_RST;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                CFG_ENABLE:     enable_reg <= cfg.data[0];
                CFG_PER_SOURCE: plim_reg   <= cfg.data[15:0];
                CFG_GLOBAL:     glim_reg   <= cfg.data[15:0];
                CFG_WINDOW:     window_reg <= cfg.data[19:0];
                default:        ;
            endcase
        end
    end

    sbr_parse #(
        .MAX_DATAGRAM (MAX_DATAGRAM)
    ) u_parse (
        .clk            (clk),
        .rst_n          (rst_n),
        .byte_fire      (byte_fire),
        .data_byte      (rx.data_byte),
        .last           (rx.last),
        .source_address (rx.source_address),
        .source_port    (rx.source_port),
        .enable         (enable_reg),
        .done           (done)
    );

    sbr_rate #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_rate (
        .clk              (clk),
        .rst_n            (rst_n),
        .tick             (tick),
        .done             (done),
        .per_source_limit (plim_reg),
        .all_src_limit    (glim_reg),
        .window_ticks     (window_reg),
        .gen_free         (gen_free),
        .clearing         (clearing),
        .busy             (s1_busy),
        .go               (go),
        .result           (result)
    );

    sbr_resp u_resp (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (go),
        .result   (result),
        .gen_free (gen_free),
        .tx       (tx)
    );

endmodule

// ===== rtl/sbr_parse.sv =====
// Datagram parser: header checks, length tracking and transaction ID capture.
// Depends on sbr_pkg.
module sbr_parse
    import sbr_pkg::*;
#(
    parameter int MAX_DATAGRAM = SBR_MAX_DATAGRAM
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        byte_fire,
    input  logic [7:0]  data_byte,
    input  logic        last,
    input  logic [31:0] source_address,
    input  logic [15:0] source_port,
    input  logic        enable,
    output sbr_done_t   done
);

    localparam int PW = $clog2(MAX_DATAGRAM + 2);

    logic [PW-1:0] pos_reg, pos_next;
    logic          hdr_ok_reg, hdr_ok_next;
    logic [15:0]   decl_reg, decl_next;
    txid_t         txid_reg, txid_now;
    logic          fail;
    logic [15:0]   decl_now;
    logic          hdr_ok_now;
    logic [PW-1:0] len;
    logic          len_ok;

    // Header checks on the current byte
    always_comb
    begin
        fail     = 1'b0;
        decl_now = decl_reg;
        txid_now = txid_reg;
        if (pos_reg < PW'(HDR_LEN))
        begin
            if (pos_reg == PW'(0))
                fail = (data_byte != 8'h00);
            else if (pos_reg == PW'(1))
                fail = (data_byte != 8'h01);
            else if (pos_reg == PW'(2))
                decl_now[15:8] = data_byte;
            else if (pos_reg == PW'(3))
                decl_now[7:0] = data_byte;
            else if (pos_reg < PW'(TXID_BASE))
                fail = (data_byte != cookie_byte(pos_reg[1:0]));
            else
                txid_now[4'(pos_reg - PW'(TXID_BASE))] = data_byte;
        end
        hdr_ok_now = hdr_ok_reg & ~fail;
        len        = (pos_reg < PW'(MAX_DATAGRAM + 1)) ? pos_reg + PW'(1) : pos_reg;
    end

    // Whole-datagram checks, valid on the last byte
    assign len_ok = (len >= PW'(HDR_LEN)) && (len <= PW'(MAX_DATAGRAM))
                    && (decl_now[1:0] == 2'b00)
                    && ({1'b0, decl_now} + 17'(HDR_LEN) == 17'(len));

    assign done.valid       = byte_fire & last;
    assign done.well_formed = enable & hdr_ok_now & len_ok;
    assign done.addr        = source_address;
    assign done.port        = source_port;
    assign done.txid        = txid_now;

    // Next datagram state; the last byte returns it to the idle values
    always_comb
    begin
        pos_next    = pos_reg;
        hdr_ok_next = hdr_ok_reg;
        decl_next   = decl_reg;
        if (byte_fire)
        begin
            if (last)
            begin
                pos_next    = '0;
                hdr_ok_next = 1'b1;
                decl_next   = '0;
            end
            else
            begin
                pos_next    = len;
                hdr_ok_next = hdr_ok_now;
                decl_next   = decl_now;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            hdr_ok_reg <= 1'b1;
            decl_reg   <= '0;
        end
        else
        begin
            pos_reg    <= pos_next;
            hdr_ok_reg <= hdr_ok_next;
            decl_reg   <= decl_next;
        end
    end

    // Transaction ID bytes; every answered datagram rewrites all twelve
    always_ff @(posedge clk)
    begin
        if (byte_fire)
            txid_reg <= txid_now;
    end

endmodule

// ===== rtl/sbr_rate.sv =====
// Rate stage: tick counter, global window, per-source bucket memory with clearing pass.
// Depends on sbr_pkg.
module sbr_rate
    import sbr_pkg::*;
#(
    parameter int TABLE_DEPTH = SBR_TABLE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        tick,
    input  sbr_done_t   done,
    input  logic [15:0] per_source_limit,
    input  logic [15:0] all_src_limit,
    input  logic [19:0] window_ticks,
    input  logic        gen_free,
    output logic        clearing,
    output logic        busy,
    output logic        go,
    output sbr_result_t result
);

    // The user keeps table depth a power of two; the block does not check. The hash keeps the product's low bits
    localparam int HW = $clog2(TABLE_DEPTH);

    sbr_bucket_t    mem [TABLE_DEPTH];
    sbr_bucket_t    rd_reg;
    sbr_bucket_t    byp_data_reg;
    logic           byp_reg;
    sbr_bucket_t    bkt;

    logic           clr_busy_reg, clr_busy_next;
    logic [HW-1:0]  clr_idx_reg, clr_idx_next;

    logic [31:0]    tick_reg;
    logic [31:0]    gws_reg, gws_next;
    logic [15:0]    gcount_reg, gcount_next;

    logic           s1_valid_reg, s1_valid_next;
    logic           s1_lookup_reg;
    logic [31:0]    s1_addr_reg;
    logic [15:0]    s1_port_reg;
    txid_t          s1_txid_reg;
    logic [HW-1:0]  s1_hash_reg;
    logic [31:0]    s1_now_reg;

    logic [31:0]    hash_prod;
    logic           rd_en;
    logic [31:0]    win32;
    logic [15:0]    plim, glim;
    logic [31:0]    g_age, b_age;
    logic           g_exp, b_new, g_ok, b_ok, allowed;
    logic [15:0]    gcnt_eff, bcnt_eff;
    logic           upd_we, mem_we;
    logic [HW-1:0]  mem_waddr;
    sbr_bucket_t    upd_data, mem_wdata;

    // Bucket hash and lookup read at the last byte
    assign hash_prod = done.addr * HASH_MUL;
    assign rd_en     = done.valid & done.well_formed;

    assign clearing = clr_busy_reg;
    assign busy     = s1_valid_reg;
    assign go       = s1_valid_reg & gen_free;

    // Bucket seen by the lookup stage; a write-back in the read cycle wins
    assign bkt = byp_reg ? byp_data_reg : rd_reg;

    // Window and limit decisions
    always_comb
    begin
        win32    = {12'b0, window_ticks};
        plim     = (per_source_limit == 16'd0) ? PLIM_DFLT : per_source_limit;
        glim     = (all_src_limit == 16'd0) ? GLIM_DFLT : all_src_limit;
        g_age    = s1_now_reg - gws_reg;
        g_exp    = (g_age >= win32);
        gcnt_eff = g_exp ? 16'd0 : gcount_reg;
        g_ok     = (gcnt_eff < glim);
        b_age    = s1_now_reg - bkt.win_start;
        b_new    = (bkt.addr != s1_addr_reg) || (b_age >= win32);
        bcnt_eff = b_new ? 16'd0 : bkt.count;
        b_ok     = (bcnt_eff < plim);
        allowed  = g_ok & b_ok;
    end

    // Global window update
    always_comb
    begin
        gws_next    = gws_reg;
        gcount_next = gcount_reg;
        if (go && s1_lookup_reg)
        begin
            if (g_exp)
                gws_next = s1_now_reg;
            gcount_next = allowed ? gcnt_eff + 16'd1 : gcnt_eff;
        end
    end

    // Bucket write-back, or the clearing pass
    always_comb
    begin
        upd_we             = go & s1_lookup_reg & g_ok & (b_new | b_ok);
        upd_data.addr      = s1_addr_reg;
        upd_data.win_start = b_new ? s1_now_reg : bkt.win_start;
        upd_data.count     = b_ok ? bcnt_eff + 16'd1 : bcnt_eff;
        mem_we             = clr_busy_reg | upd_we;
        mem_waddr          = clr_busy_reg ? clr_idx_reg : s1_hash_reg;
        mem_wdata          = clr_busy_reg ? '0 : upd_data;
    end

    // Result of the datagram
    always_comb
    begin
        if (!s1_lookup_reg)
            result.verdict = VERDICT_PASS;
        else if (allowed)
            result.verdict = VERDICT_RESP;
        else
            result.verdict = VERDICT_DROP;
        result.addr = s1_addr_reg;
        result.port = s1_port_reg;
        result.txid = s1_txid_reg;
    end

    // Clearing pass sequencing
    always_comb
    begin
        clr_busy_next = clr_busy_reg;
        clr_idx_next  = clr_idx_reg;
        if (clr_busy_reg)
        begin
            clr_idx_next = clr_idx_reg + HW'(1);
            if (clr_idx_reg == HW'(TABLE_DEPTH - 1))
                clr_busy_next = 1'b0;
        end
    end

    assign s1_valid_next = done.valid ? 1'b1 : (go ? 1'b0 : s1_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_idx_reg  <= '0;
            tick_reg     <= '0;
            gws_reg      <= '0;
            gcount_reg   <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            clr_busy_reg <= clr_busy_next;
            clr_idx_reg  <= clr_idx_next;
            if (tick)
                tick_reg <= tick_reg + 32'd1;
            gws_reg      <= gws_next;
            gcount_reg   <= gcount_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    // Lookup stage payload
    always_ff @(posedge clk)
    begin
        if (done.valid)
        begin
            s1_lookup_reg <= done.well_formed;
            s1_addr_reg   <= done.addr;
            s1_port_reg   <= done.port;
            s1_txid_reg   <= done.txid;
            s1_hash_reg   <= hash_prod[HW-1:0];
            s1_now_reg    <= tick_reg;
        end
    end

    // Bucket memory, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (rd_en)
            rd_reg <= mem[hash_prod[HW-1:0]];
    end

    // Write-back to the bucket being read in the same cycle
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            byp_reg      <= mem_we && (mem_waddr == hash_prod[HW-1:0]);
            byp_data_reg <= mem_wdata;
        end
    end

    // No datagram may reach the lookup stage before the table is clear
    a_no_lookup_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        clr_busy_reg |-> !s1_valid_reg)
        else $error("lookup stage loaded during clearing pass");

    // An answered request always leaves a nonzero global count
    a_gcount_after_allow: assert property (@(posedge clk) disable iff (!rst_n)
        go && s1_lookup_reg && allowed |=> gcount_reg != 16'd0)
        else $error("global count not advanced by an answered request");

endmodule

// ===== rtl/sbr_resp.sv =====
// Result sequencer: one verdict beat, or the 32 response bytes of an answered request.
// Depends on sbr_pkg and sbr_ifs.
module sbr_resp
    import sbr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load,
    input  sbr_result_t result,
    output logic        gen_free,
    sbr_tx_if.source    tx
);

    logic        busy_reg, busy_next;
    logic [4:0]  cnt_reg, cnt_next;
    sbr_result_t res_reg;
    logic        is_resp, fire, finish;

    assign is_resp     = (res_reg.verdict == VERDICT_RESP);
    assign tx.valid    = busy_reg;
    assign tx.verdict  = res_reg.verdict;
    assign tx.out_byte = is_resp ? resp_byte(cnt_reg, res_reg.txid, res_reg.addr,
                                             res_reg.port) : 8'h00;
    assign tx.out_last = ~is_resp | (cnt_reg == RESP_LAST);

    assign fire     = tx.valid & tx.ready;
    assign finish   = fire & tx.out_last;
    assign gen_free = ~busy_reg | finish;

    // Beat sequencing
    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        if (load)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end
        else if (finish)
        begin
            busy_next = 1'b0;
            cnt_next  = '0;
        end
        else if (fire)
            cnt_next = cnt_reg + 5'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            res_reg <= result;
    end

    // A new result only lands once the previous one is fully delivered
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        load && busy_reg |-> finish)
        else $error("result loaded over an undelivered one");

    // Single-beat verdicts never advance the byte counter
    a_cnt_only_resp: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && !is_resp |-> cnt_reg == 5'd0)
        else $error("byte counter moved on a single-beat verdict");

endmodule

// ===== tb/tb_stun_binding_responder_core.sv =====
// Self-checking testbench for stun_binding_responder_core: directed and random datagrams,
// time ticks and register settings, every response beat checked against a local predictor.
// Depends on sbr_pkg, sbr_ifs and the responder RTL.
module tb_stun_binding_responder_core;
    timeunit 1ns;
    timeprecision 1ps;

    import sbr_pkg::*;

    localparam int HALF_PERIOD      = 5;
    localparam int RESET_CYCLES     = 7;
    localparam int DRAIN_CYCLES     = 16;
    localparam int WATCHDOG_LIMIT   = 20000;
    localparam int DGRAMS_PER_PHASE = 1;
    localparam int MID_TICK_PCT     = 3;

    // Message fields of the request and the success response
    localparam logic [15:0] BINDING_REQUEST    = 16'h0001;
    localparam logic [15:0] BINDING_SUCCESS    = 16'h0101;
    localparam logic [15:0] RESP_BODY_LEN      = 16'h000C;
    localparam logic [15:0] XOR_MAPPED_ADDRESS = 16'h0020;
    localparam logic [15:0] XOR_ADDR_LEN       = 16'h0008;
    localparam logic [7:0]  FAMILY_IPV4        = 8'h01;

    // Source pool; ADDR_B_CO shares ADDR_B's bucket
    localparam logic [31:0] ADDR_A    = 32'h0A00_0001;
    localparam logic [31:0] ADDR_B    = 32'hC0A8_0105;
    localparam logic [31:0] ADDR_B_CO = ADDR_B + SBR_TABLE_DEPTH;
    localparam logic [15:0] STUN_PORT = 16'd3478;

    typedef struct packed {
        logic        opcode;
        logic [7:0]  data_byte;
        logic        last;
        logic [31:0] source_address;
        logic [15:0] source_port;
    } rx_beat_t;

    typedef struct packed {
        logic [1:0] verdict;
        logic [7:0] out_byte;
        logic       out_last;
    } tx_beat_t;

    // Predicts the result beats of every accepted input beat and checks the output
    class binding_scoreboard;
        logic        cfg_enable;
        logic [15:0] cfg_per_source;
        logic [15:0] cfg_global;
        logic [19:0] cfg_window;

        int unsigned byte_pos;
        bit          header_good;
        logic [15:0] body_len;
        logic [95:0] txn_id;

        logic [31:0] tick_now;
        logic [31:0] global_start;
        logic [15:0] global_sent;
        logic [31:0] bucket_owner [SBR_TABLE_DEPTH];
        logic [31:0] bucket_start [SBR_TABLE_DEPTH];
        logic [15:0] bucket_sent  [SBR_TABLE_DEPTH];

        tx_beat_t    reply_q[$];
        int unsigned err_count;

        function new();
            cfg_enable     = 1'b0;
            cfg_per_source = PLIM_RST;
            cfg_global     = GLIM_RST;
            cfg_window     = WINDOW_RST;
            tick_now       = '0;
            global_start   = '0;
            global_sent    = '0;
            err_count      = 0;
            for (int i = 0; i < SBR_TABLE_DEPTH; i++)
            begin
                bucket_owner[i] = '0;
                bucket_start[i] = '0;
                bucket_sent[i]  = '0;
            end
            clear_datagram();
        endfunction

        function void clear_datagram();
            byte_pos    = 0;
            header_good = 1'b1;
            body_len    = '0;
            txn_id      = '0;
        endfunction

        function void write_reg(logic [3:0] idx, logic [31:0] val);
            case (idx)
                CFG_ENABLE:     cfg_enable     = val[0];
                CFG_PER_SOURCE: cfg_per_source = val[15:0];
                CFG_GLOBAL:     cfg_global     = val[15:0];
                CFG_WINDOW:     cfg_window     = val[19:0];
                default:        ;
            endcase
        endfunction

        // Global window first, then the hashed per-source bucket
        function bit rate_admit(logic [31:0] addr);
            logic [31:0] prod;
            logic [31:0] age;
            int unsigned h;
            logic [15:0] plim;
            logic [15:0] glim;
            prod = addr * HASH_MUL;
            h    = prod % SBR_TABLE_DEPTH;
            plim = (cfg_per_source != 16'd0) ? cfg_per_source : PLIM_DFLT;
            glim = (cfg_global != 16'd0) ? cfg_global : GLIM_DFLT;
            age  = tick_now - global_start;
            if (age >= {12'd0, cfg_window})
            begin
                global_start = tick_now;
                global_sent  = '0;
            end
            if (global_sent >= glim)
                return 1'b0;
            age = tick_now - bucket_start[h];
            if (bucket_owner[h] != addr || age >= {12'd0, cfg_window})
            begin
                bucket_owner[h] = addr;
                bucket_start[h] = tick_now;
                bucket_sent[h]  = '0;
            end
            if (bucket_sent[h] >= plim)
                return 1'b0;
            bucket_sent[h] = bucket_sent[h] + 16'd1;
            global_sent    = global_sent + 16'd1;
            return 1'b1;
        endfunction

        function void predict_reply(rx_beat_t b);
            int unsigned  len;
            logic [255:0] msg;
            tx_beat_t     r;
            if (b.opcode == OP_TICK)
            begin
                tick_now = tick_now + 32'd1;
                return;
            end
            // header checks and transaction ID capture
            if (byte_pos < HDR_LEN)
            begin
                case (byte_pos)
                    // an exact type match also rules out the top two bits
                    0: if (b.data_byte != BINDING_REQUEST[15:8]) header_good = 1'b0;
                    1: if (b.data_byte != BINDING_REQUEST[7:0]) header_good = 1'b0;
                    2: body_len[15:8] = b.data_byte;
                    3: body_len[7:0]  = b.data_byte;
                    4, 5, 6, 7:
                        if (b.data_byte != COOKIE[8 * (7 - byte_pos) +: 8]) header_good = 1'b0;
                    default: txn_id[8 * (19 - byte_pos) +: 8] = b.data_byte;
                endcase
            end
            if (byte_pos < SBR_MAX_DATAGRAM + 1)
                byte_pos++;
            if (!b.last)
                return;

            len = byte_pos;
            r.out_byte = 8'h00;
            r.out_last = 1'b1;
            if (!cfg_enable || len < HDR_LEN || len > SBR_MAX_DATAGRAM || !header_good ||
                body_len[1:0] != 2'b00 || HDR_LEN + body_len != len)
            begin
                r.verdict = VERDICT_PASS;
                reply_q.push_back(r);
            end
            else if (!rate_admit(b.source_address))
            begin
                r.verdict = VERDICT_DROP;
                reply_q.push_back(r);
            end
            else
            begin
                msg = {BINDING_SUCCESS, RESP_BODY_LEN, COOKIE, txn_id,
                       XOR_MAPPED_ADDRESS, XOR_ADDR_LEN, 8'h00, FAMILY_IPV4,
                       b.source_port ^ COOKIE[31:16], b.source_address ^ COOKIE};
                for (int k = 0; k < 32; k++)
                begin
                    r.verdict  = VERDICT_RESP;
                    r.out_byte = msg[255 - 8 * k -: 8];
                    r.out_last = (k == 31);
                    reply_q.push_back(r);
                end
            end
            clear_datagram();
        endfunction

        task report_mismatch(string msg);
            $display("%0t mismatch: %s", $time, msg);
            err_count++;
        endtask

        task check_tx_beat(tx_beat_t got);
            tx_beat_t want;
            if (reply_q.size() == 0)
            begin
                report_mismatch($sformatf("unexpected beat verdict=%0d byte=%02h last=%0b",
                                          got.verdict, got.out_byte, got.out_last));
                return;
            end
            want = reply_q.pop_front();
            if (got.verdict !== want.verdict)
                report_mismatch($sformatf("verdict %0d, expected %0d", got.verdict, want.verdict));
            if (got.out_byte !== want.out_byte)
                report_mismatch($sformatf("out_byte %02h, expected %02h",
                                          got.out_byte, want.out_byte));
            if (got.out_last !== want.out_last)
                report_mismatch($sformatf("out_last %0b, expected %0b",
                                          got.out_last, want.out_last));
        endtask
    endclass

    logic clk;
    logic rst_n;
    int   send_idle_pct;
    int   recv_idle_pct;
    int   quiet_cycles;

    logic [7:0] pkt[$];
    binding_scoreboard sb;

    sbr_rx_if  rx_if();
    sbr_tx_if  tx_if();
    sbr_cfg_if cfg_if();

    stun_binding_responder_core u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_if),
        .tx    (tx_if),
        .cfg   (cfg_if)
    );

    always #HALF_PERIOD clk = ~clk;

    // Result side: random back-pressure, check every beat taken
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tx_if.ready <= 1'b0;
        else
        begin
            if (tx_if.valid && tx_if.ready)
                sb.check_tx_beat({tx_if.verdict, tx_if.out_byte, tx_if.out_last});
            tx_if.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog: cycles in a row with no beat on any channel
    always @(posedge clk)
    begin
        if ((rx_if.valid && rx_if.ready) || (tx_if.valid && tx_if.ready) ||
            (cfg_if.valid && cfg_if.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("stun_binding_responder_core test failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // One input beat, with a random gap in front of it
    task automatic send_beat(input logic op, input logic [7:0] data, input logic is_last,
                             input logic [31:0] addr, input logic [15:0] port);
        rx_beat_t beat;
        beat = {op, data, is_last, addr, port};
        while ($urandom_range(99) < send_idle_pct)
        begin
            rx_if.valid <= 1'b0;
            @(posedge clk);
        end
        rx_if.valid          <= 1'b1;
        rx_if.opcode         <= op;
        rx_if.data_byte      <= data;
        rx_if.last           <= is_last;
        rx_if.source_address <= addr;
        rx_if.source_port    <= port;
        @(posedge clk);
        while (!rx_if.ready)
            @(posedge clk);
        sb.predict_reply(beat);
    endtask

    // Ticks carry random junk in the ignored fields
    task automatic send_ticks(input int n);
        repeat (n)
            send_beat(OP_TICK, 8'($urandom), 1'($urandom), $urandom, 16'($urandom));
    endtask

    // Send pkt; the source is only meaningful on the last byte
    task automatic send_datagram(input logic [31:0] addr, input logic [15:0] port);
        bit fin;
        for (int i = 0; i < pkt.size(); i++)
        begin
            fin = (i == pkt.size() - 1);
            if ($urandom_range(99) < MID_TICK_PCT)
                send_ticks($urandom_range(1, 3));
            send_beat(OP_BYTE, pkt[i], fin, fin ? addr : $urandom,
                      fin ? port : 16'($urandom));
        end
    endtask

    // Binding Request with a random transaction ID and body; well-formed when body is a multiple of four
    task automatic make_request(input int unsigned body);
        logic [15:0] blen;
        blen = body[15:0];
        pkt.delete();
        pkt.push_back(BINDING_REQUEST[15:8]);
        pkt.push_back(BINDING_REQUEST[7:0]);
        pkt.push_back(blen[15:8]);
        pkt.push_back(blen[7:0]);
        for (int i = 3; i >= 0; i--)
            pkt.push_back(COOKIE[8 * i +: 8]);
        repeat (HDR_LEN - TXID_BASE + body)
            pkt.push_back(8'($urandom));
    endtask

    // Wait until every expected beat is out and the pipeline has gone quiet
    task automatic settle();
        rx_if.valid <= 1'b0;
        while (sb.reply_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [3:0] idx, input logic [31:0] val);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
        sb.write_reg(idx, val);
    endtask

    // Program all registers while idle; unused data bits are random
    task automatic configure(input logic en, input logic [15:0] per_src,
                             input logic [15:0] glob, input logic [19:0] win);
        logic [31:0] val;
        settle();
        write_reg(4'(CFG_WINDOW + 4'($urandom_range(1, 12))), $urandom);
        val = $urandom;
        val[0] = en;
        write_reg(CFG_ENABLE, val);
        val = $urandom;
        val[15:0] = per_src;
        write_reg(CFG_PER_SOURCE, val);
        val = $urandom;
        val[15:0] = glob;
        write_reg(CFG_GLOBAL, val);
        val = $urandom;
        val[19:0] = win;
        write_reg(CFG_WINDOW, val);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic run_directed();
        // reset state is disabled: a good request passes through
        make_request(0);
        send_datagram(ADDR_A, STUN_PORT);
        configure(1'b1, 16'd1, 16'd0, 20'd2);
        // zero transaction ID from address zero, which hits a never-used bucket
        make_request(0);
        for (int i = TXID_BASE; i < HDR_LEN; i++)
            pkt[i] = 8'h00;
        send_datagram(32'h0, 16'h0);
        // same source within its window: over the per-source limit of one
        make_request(0);
        send_datagram(32'h0, 16'hFFFF);
        // let the window run out, then a single-byte datagram
        send_ticks(2);
        pkt.delete();
        pkt.push_back(8'h00);
        send_datagram(ADDR_A, STUN_PORT);
    endtask

    // Mostly good requests from a small pool of sources, the rest broken
    task automatic random_datagram();
        int unsigned kind;
        int unsigned pos;
        logic [31:0] addr;
        logic [15:0] port;
        case ($urandom_range(9))
            0:       addr = 32'h0;
            1:       addr = 32'hFFFF_FFFF;
            2, 3:    addr = ADDR_A;
            4:       addr = ADDR_B_CO;
            5, 6:    addr = ADDR_B;
            default: addr = $urandom;
        endcase
        port = ($urandom_range(9) == 0) ? 16'hFFFF : 16'($urandom);
        kind = $urandom_range(99);
        if (kind < 74)
            make_request(($urandom_range(9) < 7) ? 0 : 4 * $urandom_range(1, 6));
        else if (kind < 80)
        begin
            // single bit error in type, length or cookie
            make_request(4 * $urandom_range(0, 2));
            pos = $urandom_range(0, 7);
            pkt[pos] = pkt[pos] ^ (8'h01 << $urandom_range(0, 7));
        end
        else if (kind < 84)
            make_request(4 * $urandom_range(0, 4) + $urandom_range(1, 3));
        else if (kind < 88)
        begin
            make_request(4 * $urandom_range(0, 3));
            repeat ($urandom_range(1, pkt.size() - 1))
                void'(pkt.pop_back());
        end
        else if (kind < 92)
        begin
            make_request(4 * $urandom_range(0, 3));
            repeat ($urandom_range(1, 4))
                pkt.push_back(8'($urandom));
        end
        else if (kind < 94)
        begin
            make_request(0);
            pkt[0][7:6] = 2'($urandom_range(1, 3));
        end
        else
        begin
            pkt.delete();
            repeat ($urandom_range(1, 40))
                pkt.push_back(8'($urandom));
        end
        send_datagram(addr, port);
    endtask

    task automatic run_phase(input logic en, input logic [15:0] per_src,
                             input logic [15:0] glob, input logic [19:0] win);
        configure(en, per_src, glob, win);
        repeat (DGRAMS_PER_PHASE)
        begin
            if ($urandom_range(99) < 25)
                send_ticks($urandom_range(1, 4));
            random_datagram();
        end
    endtask

    initial
    begin
        clk                  = 1'b0;
        rst_n                = 1'b0;
        quiet_cycles         = 0;
        send_idle_pct        = 10;
        recv_idle_pct        = 86;
        rx_if.valid          = 1'b0;
        rx_if.opcode         = OP_BYTE;
        rx_if.data_byte      = '0;
        rx_if.last           = 1'b0;
        rx_if.source_address = '0;
        rx_if.source_port    = '0;
        tx_if.ready          = 1'b0;
        cfg_if.valid         = 1'b0;
        cfg_if.index         = CFG_ENABLE;
        cfg_if.data          = '0;
        sb = new();
        repeat (RESET_CYCLES)
            @(posedge clk);
        rst_n <= 1'b1;

        run_directed();
        run_phase(1'b1, 16'd2, 16'd0, 20'd3);

        // sender mostly idle, receiver mostly ready
        send_idle_pct = 86;
        recv_idle_pct = 10;
        run_phase(1'b1, 16'd1, 16'hFFFF, 20'd0);
        run_phase(1'b1, 16'hFFFF, 16'd1, 20'hFFFFF);

        // full throughput both ways
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_phase(1'b1, 16'd0, 16'd0, 20'd100);
        run_phase(1'b1, 16'd2, 16'd5, 20'($urandom_range(1, 200)));

        settle();
        if (sb.err_count == 0)
            $display("stun_binding_responder_core test passed");
        else
            $display("stun_binding_responder_core test failed");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/sbr_pkg.sv
rtl/sbr_ifs.sv
rtl/sbr_parse.sv
rtl/sbr_rate.sv
rtl/sbr_resp.sv
rtl/stun_binding_responder_core.sv
tb/tb_stun_binding_responder_core.sv
